// ----- rtl/cmdt_pkg.sv -----
// Shared constants for the cube map direction texel fetch block.
// Used by the channel interfaces, the RAM user and the top level.
`default_nettype none
package cmdt_pkg;
  localparam int MAX_FACE_SIZE = 128;
  localparam int FACE_COUNT    = 6;
  localparam int COORD_W       = 7;
  localparam int DIR_W         = 16;
  localparam int FACE_W        = 3;
  localparam int COLOR_W       = 8;
  localparam int TEXEL_W       = 3 * COLOR_W;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 8;

  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 8'd128;

  localparam logic [CFG_IDX_W-1:0] REG_FACE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_HEIGHT = 1'b1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;
endpackage
`default_nettype wire

// ----- rtl/cmdt_if.sv -----
// Request and response channel interfaces (valid/ready plus payload).
// Depends on cmdt_pkg.
`default_nettype none
interface cmdt_req_if #(parameter int COORD_W = cmdt_pkg::COORD_W);
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic signed [15:0]   dir_x;
  logic signed [15:0]   dir_y;
  logic signed [15:0]   dir_z;
  logic [2:0]           load_face;
  logic [COORD_W-1:0]   load_col;
  logic [COORD_W-1:0]   load_row;
  logic [7:0]           load_red;
  logic [7:0]           load_green;
  logic [7:0]           load_blue;
  modport source (output valid, op, dir_x, dir_y, dir_z, load_face, load_col, load_row,
                  load_red, load_green, load_blue, input ready);
  modport sink (input valid, op, dir_x, dir_y, dir_z, load_face, load_col, load_row,
                load_red, load_green, load_blue, output ready);
endinterface

interface cmdt_rsp_if #(parameter int COORD_W = cmdt_pkg::COORD_W);
  logic               valid;
  logic               ready;
  logic [2:0]         hit_face;
  logic [COORD_W-1:0] hit_col;
  logic [COORD_W-1:0] hit_row;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               zero_direction;
  modport source (output valid, hit_face, hit_col, hit_row, red, green, blue, zero_direction,
                  input ready);
  modport sink (input valid, hit_face, hit_col, hit_row, red, green, blue, zero_direction,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/cmdt_ram.sv -----
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module cmdt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/cube_map_direction_texel_fetch.sv -----
// Cube map face selection and texel fetch over a six-face RGB8 texel RAM.
// Depends on cmdt_pkg, cmdt_if (cmdt_req_if, cmdt_rsp_if) and cmdt_ram.
//
//   channel | dir | carries
//   req     | in  | texel write (op=0) or direction lookup (op=1)
//   rsp     | out | face, texel position, color, zero-direction flag
//   cfg     | in  | face_width (index 0), face_height (index 1)
//
// A write gives no item. A lookup runs through absolute values, face select, scale
// multiply, SIZE_W steps of the shared restoring divider, clamp, RAM read and output
// load. A zero direction goes from the absolute values straight to the output load.
// Reset is synchronous and clears control only;
// the texel RAM is undefined until written. A stalled rsp holds its item; the
// next req item is taken while it waits, and the block stops before the output load.
`default_nettype none
module cube_map_direction_texel_fetch #(
  parameter int MAX_SIZE = cmdt_pkg::MAX_FACE_SIZE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cmdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cmdt_pkg::CFG_DATA_W-1:0]   cfg_data,
  cmdt_req_if.sink                          req,
  cmdt_rsp_if.source                        rsp
);
  import cmdt_pkg::*;

  localparam int SIZE_W = $clog2(MAX_SIZE + 1);
  localparam int CW     = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int QW     = SIZE_W;
  localparam int MAG_W  = DIR_W + 1;
  localparam int PROD_W = MAG_W + SIZE_W;
  localparam int CNT_W  = (QW > 1) ? $clog2(QW) : 1;
  localparam int DEPTH  = FACE_COUNT * MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_ABS, S_SEL, S_MUL, S_DIV, S_CLAMP, S_READ, S_OUT
  } state_t;

  state_t state;

  logic [CFG_DATA_W-1:0] width_reg, height_reg;
  logic [SIZE_W-1:0]     w_eff, h_eff;

  logic signed [DIR_W-1:0] dx, dy, dz;
  logic [MAG_W-1:0]  ax, ay, az;
  logic              zero;
  logic [FACE_W-1:0] face;
  logic [MAG_W-1:0]  num_col, num_row, den;
  logic [PROD_W-1:0] rem_col, rem_row, dsh;
  logic [QW-1:0]     q_col, q_row;
  logic [CNT_W-1:0]  cnt;
  logic [CW-1:0]     col, row;

  logic [FACE_W-1:0] sel_face;
  logic [MAG_W-1:0]  sel_ma;
  logic [MAG_W-1:0]  sel_num_col, sel_num_row;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [TEXEL_W-1:0] ram_rdata;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_DATA_W-1:0] r);
    if (r == '0) begin
      return SIZE_W'(1);
    end
    if (int'(r) > MAX_SIZE) begin
      return SIZE_W'(MAX_SIZE);
    end
    return SIZE_W'(r);
  endfunction

  function automatic logic [MAG_W-1:0] num_of(input logic [MAG_W-1:0] ma,
                                              input logic signed [DIR_W-1:0] c,
                                              input logic flip);
    logic signed [MAG_W:0] s;
    logic signed [MAG_W:0] ce;
    ce = (MAG_W+1)'(c);
    s  = flip ? ($signed({1'b0, ma}) - ce) : ($signed({1'b0, ma}) + ce);
    if (s[MAG_W]) begin
      return '0;
    end
    return s[MAG_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [FACE_W-1:0] f,
                                                input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
    return ADDR_W'(f) * ADDR_W'(MAX_SIZE * MAX_SIZE) + ADDR_W'(r) * ADDR_W'(MAX_SIZE)
           + ADDR_W'(c);
  endfunction

  assign w_eff = eff_size(width_reg);
  assign h_eff = eff_size(height_reg);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= SIZE_RESET;
      height_reg <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FACE_WIDTH:  width_reg  <= cfg_data;
        REG_FACE_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ax >= ay && ax >= az) begin
      sel_ma   = ax;
      sel_face = (!dx[DIR_W-1] && dx != '0) ? FACE_PX : FACE_NX;
    end else if (ay >= az) begin
      sel_ma   = ay;
      sel_face = (!dy[DIR_W-1] && dy != '0) ? FACE_PY : FACE_NY;
    end else begin
      sel_ma   = az;
      sel_face = (!dz[DIR_W-1] && dz != '0) ? FACE_PZ : FACE_NZ;
    end
    case (sel_face)
      FACE_PX: begin
        sel_num_col = num_of(sel_ma, dz, 1'b1);
        sel_num_row = num_of(sel_ma, dy, 1'b1);
      end
      FACE_NX: begin
        sel_num_col = num_of(sel_ma, dz, 1'b0);
        sel_num_row = num_of(sel_ma, dy, 1'b1);
      end
      FACE_PY: begin
        sel_num_col = num_of(sel_ma, dx, 1'b0);
        sel_num_row = num_of(sel_ma, dz, 1'b0);
      end
      FACE_NY: begin
        sel_num_col = num_of(sel_ma, dz, 1'b0);
        sel_num_row = num_of(sel_ma, dx, 1'b0);
      end
      FACE_PZ: begin
        sel_num_col = num_of(sel_ma, dx, 1'b0);
        sel_num_row = num_of(sel_ma, dy, 1'b1);
      end
      default: begin
        sel_num_col = num_of(sel_ma, dx, 1'b1);
        sel_num_row = num_of(sel_ma, dy, 1'b1);
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);
  assign ram_we    = req.valid && req.ready && (req.op == OP_WRITE)
                     && (int'(req.load_face) < FACE_COUNT)
                     && (int'(req.load_col) < MAX_SIZE) && (int'(req.load_row) < MAX_SIZE);
  assign ram_waddr = addr_of(req.load_face, CW'(req.load_row), CW'(req.load_col));
  assign ram_raddr = addr_of(face, row, col);

  cmdt_ram #(.WIDTH(TEXEL_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({req.load_red, req.load_green, req.load_blue}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_OUT) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && req.op == OP_LOOKUP) begin
            dx    <= req.dir_x;
            dy    <= req.dir_y;
            dz    <= req.dir_z;
            state <= S_ABS;
          end
        end
        S_ABS: begin
          ax    <= dx[DIR_W-1] ? (~MAG_W'(dx) + MAG_W'(1)) : MAG_W'(dx);
          ay    <= dy[DIR_W-1] ? (~MAG_W'(dy) + MAG_W'(1)) : MAG_W'(dy);
          az    <= dz[DIR_W-1] ? (~MAG_W'(dz) + MAG_W'(1)) : MAG_W'(dz);
          zero  <= (dx == '0) && (dy == '0) && (dz == '0);
          state <= ((dx == '0) && (dy == '0) && (dz == '0)) ? S_OUT : S_SEL;
        end
        S_SEL: begin
          face    <= sel_face;
          num_col <= sel_num_col;
          num_row <= sel_num_row;
          den     <= {sel_ma[MAG_W-2:0], 1'b0};
          state   <= S_MUL;
        end
        S_MUL: begin
          rem_col <= PROD_W'(num_col) * PROD_W'(w_eff);
          rem_row <= PROD_W'(num_row) * PROD_W'(h_eff);
          dsh     <= PROD_W'(den) << (QW - 1);
          q_col   <= '0;
          q_row   <= '0;
          cnt     <= CNT_W'(QW - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          if (rem_col >= dsh) begin
            rem_col <= rem_col - dsh;
            q_col   <= QW'({q_col, 1'b1});
          end else begin
            q_col   <= QW'({q_col, 1'b0});
          end
          if (rem_row >= dsh) begin
            rem_row <= rem_row - dsh;
            q_row   <= QW'({q_row, 1'b1});
          end else begin
            q_row   <= QW'({q_row, 1'b0});
          end
          dsh <= dsh >> 1;
          cnt <= cnt - CNT_W'(1);
          if (cnt == '0) begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          col   <= (q_col > w_eff - SIZE_W'(1)) ? CW'(w_eff - SIZE_W'(1)) : CW'(q_col);
          row   <= (q_row > h_eff - SIZE_W'(1)) ? CW'(h_eff - SIZE_W'(1)) : CW'(q_row);
          state <= S_READ;
        end
        S_READ: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid          <= 1'b1;
            rsp.zero_direction <= zero;
            rsp.hit_face       <= zero ? '0 : face;
            rsp.hit_col        <= zero ? '0 : COORD_W'(col);
            rsp.hit_row        <= zero ? '0 : COORD_W'(row);
            rsp.red            <= zero ? '0 : ram_rdata[TEXEL_W-1 -: COLOR_W];
            rsp.green          <= zero ? '0 : ram_rdata[2*COLOR_W-1 -: COLOR_W];
            rsp.blue           <= zero ? '0 : ram_rdata[COLOR_W-1:0];
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/cmdt_checker.sv -----
// Port-level checker for cube_map_direction_texel_fetch, with its bind.
// Depends on cmdt_pkg and the top level's ports.
`default_nettype none
module cmdt_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_op,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [2:0] hit_face,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       zero_direction
);
  import cmdt_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp item dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(hit_face) && $stable(red) && $stable(zero_direction))
    else $error("rsp item changed while stalled");

  a_zero_black: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && zero_direction |-> hit_face == FACE_PX && red == '0 && green == '0
    && blue == '0) else $error("zero direction item not black");

  a_face_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> int'(hit_face) < FACE_COUNT) else $error("face out of range");

  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_op == OP_LOOKUP |=> !req_ready)
    else $error("lookup item accepted without going busy");
endmodule

bind cube_map_direction_texel_fetch cmdt_checker u_cmdt_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_op         (req.op),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .hit_face       (rsp.hit_face),
  .red            (rsp.red),
  .green          (rsp.green),
  .blue           (rsp.blue),
  .zero_direction (rsp.zero_direction)
);
`default_nettype wire
